@@ src/psh_pkg.sv @@
// ----------------------------------------------------------------------------
// psh_pkg
// Shared types and constants of the packet header splitter.
// ----------------------------------------------------------------------------
package psh_pkg;

   localparam int LEN_W = 16;        // width of offsets, lengths and counts on the ports
   localparam int QUEUE_DEPTH = 2;   // frame summaries between front and back

   localparam logic [15:0] LINK_ETHER    = 16'd1;
   localparam logic [15:0] LINK_LOOPBACK = 16'd772;
   localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
   localparam logic [15:0] ETYPE_ARP     = 16'h0806;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;

   localparam logic [15:0] LINK_REC_LEN = 16'd20;
   localparam logic [15:0] ETH_LEN      = 16'd14;
   localparam logic [15:0] IPV4_MIN     = 16'd20;
   localparam logic [15:0] TCP_MIN      = 16'd20;
   localparam logic [15:0] UDP_LEN      = 16'd8;
   localparam logic [15:0] ARP_FIXED    = 16'd8;

   typedef enum logic [2:0] {
      REC_LINK    = 3'd0,
      REC_ETH     = 3'd1,
      REC_ARP     = 3'd2,
      REC_IPV4    = 3'd3,
      REC_TCP     = 3'd4,
      REC_UDP     = 3'd5,
      REC_PAYLOAD = 3'd6
   } rec_kind_type;

   // header fields of one finished frame
   typedef struct packed {
      logic [LEN_W-1:0] size;
      logic             link_eth;
      logic [15:0]      eth_type;
      logic [3:0]       ip_hdr_words;
      logic [15:0]      ip_total_len;
      logic [7:0]       ip_proto;
      logic [3:0]       tcp_hdr_words;
      logic [7:0]       arp_hw_len;
      logic [7:0]       arp_proto_len;
   } frame_sum_type;

endpackage

@@ src/psh_front.sv @@
// ----------------------------------------------------------------------------
// psh_front
// Byte intake: counts frame bytes, captures header fields, and pushes one
// frame summary into the queue on the last beat of a frame.
// ----------------------------------------------------------------------------
module psh_front #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic [15:0]           req_tuser,
   input  logic                  req_tlast,
   input  logic                  q_full,
   output logic                  q_push,
   output psh_pkg::frame_sum_type q_data
);

   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

   logic [LENGTH_BITS-1:0] count_ff, count_in, count_next;
   logic        link_eth_ff, link_eth_in;
   logic [15:0] etype_ff, etype_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [7:0]  proto_ff, proto_in;
   logic [3:0]  thl_ff, thl_in;
   logic [7:0]  arp_hw_ff, arp_hw_in;
   logic [7:0]  arp_pr_ff, arp_pr_in;

   logic                   accept;
   logic [LENGTH_BITS-1:0] tcp_idx;

   logic        link_eth_cap;
   logic [15:0] etype_cap, tlen_cap;
   logic [3:0]  ihl_cap, thl_cap;
   logic [7:0]  proto_cap, arp_hw_cap, arp_pr_cap;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

   // TCP data offset sits 12 bytes into the transport header
   assign tcp_idx = LENGTH_BITS'(26) + LENGTH_BITS'({ihl_ff, 2'b00});

   always_comb begin
      link_eth_cap = link_eth_ff;
      etype_cap    = etype_ff;
      ihl_cap      = ihl_ff;
      tlen_cap     = tlen_ff;
      proto_cap    = proto_ff;
      thl_cap      = thl_ff;
      arp_hw_cap   = arp_hw_ff;
      arp_pr_cap   = arp_pr_ff;
      if (count_ff == '0) begin
         link_eth_cap = (req_tuser == psh_pkg::LINK_ETHER) ||
                        (req_tuser == psh_pkg::LINK_LOOPBACK);
      end
      if (count_ff == LENGTH_BITS'(12)) etype_cap[15:8] = req_tdata;
      if (count_ff == LENGTH_BITS'(13)) etype_cap[7:0]  = req_tdata;
      if (count_ff == LENGTH_BITS'(14)) ihl_cap         = req_tdata[3:0];
      if (count_ff == LENGTH_BITS'(16)) tlen_cap[15:8]  = req_tdata;
      if (count_ff == LENGTH_BITS'(17)) tlen_cap[7:0]   = req_tdata;
      if (count_ff == LENGTH_BITS'(23)) proto_cap       = req_tdata;
      if (count_ff == LENGTH_BITS'(18)) arp_hw_cap      = req_tdata;
      if (count_ff == LENGTH_BITS'(19)) arp_pr_cap      = req_tdata;
      if ((count_ff > LENGTH_BITS'(14)) && (count_ff == tcp_idx)) begin
         thl_cap = req_tdata[7:4];
      end
   end

   always_comb begin
      q_push              = accept && req_tlast;
      q_data.size         = psh_pkg::LEN_W'(count_next);
      q_data.link_eth     = link_eth_cap;
      q_data.eth_type     = etype_cap;
      q_data.ip_hdr_words = ihl_cap;
      q_data.ip_total_len = tlen_cap;
      q_data.ip_proto     = proto_cap;
      q_data.tcp_hdr_words = thl_cap;
      q_data.arp_hw_len   = arp_hw_cap;
      q_data.arp_proto_len = arp_pr_cap;
   end

   always_comb begin
      count_in    = count_ff;
      link_eth_in = link_eth_ff;
      etype_in    = etype_ff;
      ihl_in      = ihl_ff;
      tlen_in     = tlen_ff;
      proto_in    = proto_ff;
      thl_in      = thl_ff;
      arp_hw_in   = arp_hw_ff;
      arp_pr_in   = arp_pr_ff;
      if (accept) begin
         if (req_tlast) begin
            // frame done: start the next one from scratch
            count_in    = '0;
            link_eth_in = 1'b0;
            etype_in    = '0;
            ihl_in      = '0;
            tlen_in     = '0;
            proto_in    = '0;
            thl_in      = '0;
            arp_hw_in   = '0;
            arp_pr_in   = '0;
         end else begin
            count_in    = count_next;
            link_eth_in = link_eth_cap;
            etype_in    = etype_cap;
            ihl_in      = ihl_cap;
            tlen_in     = tlen_cap;
            proto_in    = proto_cap;
            thl_in      = thl_cap;
            arp_hw_in   = arp_hw_cap;
            arp_pr_in   = arp_pr_cap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         link_eth_ff <= 1'b0;
         etype_ff    <= '0;
         ihl_ff      <= '0;
         tlen_ff     <= '0;
         proto_ff    <= '0;
         thl_ff      <= '0;
         arp_hw_ff   <= '0;
         arp_pr_ff   <= '0;
      end else begin
         count_ff    <= count_in;
         link_eth_ff <= link_eth_in;
         etype_ff    <= etype_in;
         ihl_ff      <= ihl_in;
         tlen_ff     <= tlen_in;
         proto_ff    <= proto_in;
         thl_ff      <= thl_in;
         arp_hw_ff   <= arp_hw_in;
         arp_pr_ff   <= arp_pr_in;
      end
   end

endmodule

@@ src/psh_queue.sv @@
// ----------------------------------------------------------------------------
// psh_queue
// Short FIFO of frame summaries between the intake and the record emitter.
// ----------------------------------------------------------------------------
module psh_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  psh_pkg::frame_sum_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output psh_pkg::frame_sum_type head_data
);

   localparam int DEPTH = psh_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   psh_pkg::frame_sum_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ src/psh_back.sv @@
// ----------------------------------------------------------------------------
// psh_back
// Record emitter: takes one frame summary, works out its header records and
// sends them one beat at a time through an output register.
// ----------------------------------------------------------------------------
module psh_back #(
   parameter int MAX_RECORDS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  psh_pkg::frame_sum_type q_data,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,
   output logic [2:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam logic [3:0] MAX_R = 4'(MAX_RECORDS);

   psh_pkg::frame_sum_type cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [2:0] idx_ff, idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   psh_pkg::rec_kind_type rsp_kind_ff, rsp_kind_in;
   logic [15:0]           rsp_off_ff, rsp_off_in;
   logic [15:0]           rsp_len_ff, rsp_len_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [15:0] hl, th, al, rem_eth, ip_pay, l4_len, l4_off;
   logic [15:0] pay_off, pay_len;
   logic        eth_ok, ip_ok, tcp_ok, udp_ok, arp_ok;
   logic [2:0]  n_hdr, total;
   logic [3:0]  kept;
   logic        out_free, emit, is_last, fin;

   psh_pkg::rec_kind_type sel_kind;
   logic [15:0]           sel_off, sel_len;

   // parse decisions for the frame in hand
   always_comb begin
      hl      = {10'b0, cur_ff.ip_hdr_words, 2'b00};
      th      = {10'b0, cur_ff.tcp_hdr_words, 2'b00};
      al      = psh_pkg::ARP_FIXED + {7'b0, cur_ff.arp_hw_len, 1'b0}
                + {7'b0, cur_ff.arp_proto_len, 1'b0};
      eth_ok  = cur_ff.link_eth && (cur_ff.size >= psh_pkg::ETH_LEN);
      rem_eth = cur_ff.size - psh_pkg::ETH_LEN;
      ip_ok   = eth_ok && (cur_ff.eth_type == psh_pkg::ETYPE_IPV4)
                && (rem_eth >= psh_pkg::IPV4_MIN) && (rem_eth >= hl)
                && (rem_eth >= cur_ff.ip_total_len) && (cur_ff.ip_total_len >= hl);
      ip_pay  = cur_ff.ip_total_len - hl;
      tcp_ok  = ip_ok && (cur_ff.ip_proto == psh_pkg::PROTO_TCP)
                && (ip_pay >= psh_pkg::TCP_MIN) && (ip_pay >= th);
      udp_ok  = ip_ok && (cur_ff.ip_proto == psh_pkg::PROTO_UDP)
                && (ip_pay >= psh_pkg::UDP_LEN);
      arp_ok  = eth_ok && (cur_ff.eth_type == psh_pkg::ETYPE_ARP)
                && (rem_eth >= psh_pkg::ARP_FIXED) && (rem_eth >= al);
      l4_len  = tcp_ok ? th : (udp_ok ? psh_pkg::UDP_LEN : 16'd0);
      l4_off  = psh_pkg::ETH_LEN + hl;

      if (arp_ok) begin
         pay_off = psh_pkg::ETH_LEN + al;
         pay_len = 16'd0;
      end else if (ip_ok) begin
         pay_off = l4_off + l4_len;
         pay_len = ip_pay - l4_len;
      end else if (eth_ok) begin
         pay_off = psh_pkg::ETH_LEN;
         pay_len = rem_eth;
      end else begin
         pay_off = 16'd0;
         pay_len = cur_ff.size;
      end

      // headers found form a prefix of link, eth, ipv4/arp, tcp/udp
      n_hdr = 3'd1 + {2'b0, eth_ok} + {2'b0, ip_ok || arp_ok} + {2'b0, tcp_ok || udp_ok};
      total = n_hdr + 3'd1;
      kept  = ({1'b0, total} > MAX_R) ? MAX_R : {1'b0, total};
   end

   always_comb begin
      sel_kind = psh_pkg::REC_PAYLOAD;
      sel_off  = pay_off;
      sel_len  = pay_len;
      if (idx_ff < n_hdr) begin
         case (idx_ff)
            3'd0: begin
               sel_kind = psh_pkg::REC_LINK;
               sel_off  = 16'd0;
               sel_len  = psh_pkg::LINK_REC_LEN;
            end
            3'd1: begin
               sel_kind = psh_pkg::REC_ETH;
               sel_off  = 16'd0;
               sel_len  = psh_pkg::ETH_LEN;
            end
            3'd2: begin
               sel_kind = arp_ok ? psh_pkg::REC_ARP : psh_pkg::REC_IPV4;
               sel_off  = psh_pkg::ETH_LEN;
               sel_len  = arp_ok ? al : hl;
            end
            3'd3: begin
               sel_kind = tcp_ok ? psh_pkg::REC_TCP : psh_pkg::REC_UDP;
               sel_off  = l4_off;
               sel_len  = l4_len;
            end
            default: begin
               sel_kind = psh_pkg::REC_PAYLOAD;
               sel_off  = pay_off;
               sel_len  = pay_len;
            end
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit     = cur_valid_ff && out_free;
   assign is_last  = ({1'b0, idx_ff} == (kept - 4'd1));
   assign fin      = emit && is_last;
   assign q_pop    = q_valid && (!cur_valid_ff || fin);

   always_comb begin
      cur_in       = q_pop ? q_data : cur_ff;
      cur_valid_in = q_pop ? 1'b1 : (fin ? 1'b0 : cur_valid_ff);
      idx_in       = (q_pop || fin) ? 3'd0 : (emit ? idx_ff + 3'd1 : idx_ff);

      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_kind_in  = emit ? sel_kind : rsp_kind_ff;
      rsp_off_in   = emit ? sel_off : rsp_off_ff;
      rsp_len_in   = emit ? sel_len : rsp_len_ff;
      rsp_last_in  = emit ? is_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_len_ff, rsp_off_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> ({1'b0, idx_ff} < kept))
      else $error("record index past kept count");

   a_idx_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !cur_valid_ff |-> (idx_ff == 3'd0))
      else $error("record index not cleared between frames");

   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff && (MAX_R >= 4'd5)) |->
      (rsp_kind_ff == psh_pkg::REC_PAYLOAD))
      else $error("frame ended on a non-payload record");

   a_fin_frees_or_reloads: assert property (@(posedge clock) disable iff (reset)
      (fin && !q_valid) |=> !cur_valid_ff)
      else $error("frame held after its last record");
`endif

endmodule

@@ src/packet_header_splitter.sv @@
// ----------------------------------------------------------------------------
// packet_header_splitter
// Splits each frame, one byte per beat, into link/ethernet/arp/ipv4/tcp/udp
// and payload header records, emitted after the frame's last byte.
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tuser             tlast
// req      in   [7:0] frame_byte               [15:0] link_type  end_of_frame
// rsp      out  [15:0] record_offset,          [2:0] record_type last_record
//               [31:16] record_length
//
// Intake takes one byte per cycle; a frame summary goes to a two-entry queue
// on the last byte. The emitter sends one record per cycle, 2 to 5 per frame
// (capped at MAX_RECORDS), so short frames are limited by the emitter.
// The last byte's summary reaches rsp via queue, frame and output registers.
// Synchronous reset clears counters, queue and output valid.
// req_tready drops only while the queue is full; rsp stalls hold the output
// register and back up into the queue.
// ----------------------------------------------------------------------------
module packet_header_splitter #(
   parameter int MAX_RECORDS = 8,
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // frame_byte
   input  logic [15:0] req_tuser,   // link_type
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // record_offset, record_length
   output logic [2:0]  rsp_tuser,   // record_type
   output logic        rsp_tlast
);

   logic                   q_full, q_push, q_pop, q_valid;
   psh_pkg::frame_sum_type q_in, q_head;

   psh_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_in)
   );

   psh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   psh_back #(
      .MAX_RECORDS(MAX_RECORDS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
